// File: rtl/msna_pkg.sv
`default_nettype none
package msna_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int WEIGHT_DEPTH_DEF = 256;

  localparam int COORD_W  = 16;
  localparam int BW_W     = 16;
  localparam int WEIGHT_W = 16;
  localparam int PT_W     = 2 * COORD_W;
  // h^2 in Q16.16 scaled by 2^13
  localparam int DEN_W    = 2 * BW_W + 13;
  localparam int MEAN_W   = COORD_W + 2;
  localparam int OIDX_W   = 6;

  localparam logic [BW_W-1:0] BW_RESET = 16'd1280;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic [OIDX_W-1:0] point_index;
    logic [OIDX_W-1:0] cluster_index;
    logic              last_result;
  } out_beat_t;

  // shifted mean of one point, passed from the kernel stage to the search stage
  typedef struct packed {
    logic [OIDX_W-1:0]        point_index;
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic                     last;
  } mean_t;

  // Gaussian weight entry: 65536*exp(-s) with s = k/depth in Q.32, raised
  // to the 16th power by four squarings. s is supplied by the caller.
  function automatic logic [WEIGHT_W-1:0] table_entry(input logic [63:0] k,
                                                      input logic [63:0] s);
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [65:0] sum;
    logic [63:0]        e;
    logic [WEIGHT_W-1:0] res;
    term = 64'd1 << 32;
    sum  = 66'sd1 <<< 32;
    res  = 16'hFFFF;
    if (k != 64'd0) begin
      for (int n = 1; n <= 14; n++) begin
        prod = (term * s) >> 32;
        case (n)
          1:       term = prod;
          2:       term = prod / 2;
          3:       term = prod / 3;
          4:       term = prod / 4;
          5:       term = prod / 5;
          6:       term = prod / 6;
          7:       term = prod / 7;
          8:       term = prod / 8;
          9:       term = prod / 9;
          10:      term = prod / 10;
          11:      term = prod / 11;
          12:      term = prod / 12;
          13:      term = prod / 13;
          default: term = prod / 14;
        endcase
        if ((n % 2) == 1) begin
          sum = sum - $signed({2'b00, term});
        end else begin
          sum = sum + $signed({2'b00, term});
        end
      end
      if (sum < 0) begin
        e = 64'd0;
      end else if (sum > 66'sh0_FFFF_FFFF) begin
        e = 64'hFFFF_FFFF;
      end else begin
        e = sum[63:0];
      end
      for (int r = 0; r < 4; r++) begin
        e = (e * e + (64'd1 << 31)) >> 32;
      end
      e = (e + 64'd32768) >> 16;
      res = (e > 64'd65535) ? 16'hFFFF : e[WEIGHT_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mean_shift_nearest_assign_core.sv
`default_nettype none
// Channel  | Ports                          | Beat
// ---------+--------------------------------+---------------------------------
// input    | push, full, in_data            | in_beat_t: one sample point
// result   | empty, pop, out_data           | out_beat_t: one point assignment
// config   | cfg_wr_en, cfg_wr_data         | bandwidth h, unsigned Q8.8
//
// Loading accepts one point per cycle while full is low. The final point
// starts clustering; each point's mean is formed in the kernel unit (pair
// pipeline plus a 17-step mean divide), while the nearest-sample search of
// the previous point runs alongside. Reset clears control and sets the
// bandwidth register to BW_RESET; the point store is left as is. full stays
// high from the final point until its last result is popped.
module mean_shift_nearest_assign_core #(
  parameter int MAX_POINTS         = msna_pkg::MAX_POINTS_DEF,
  parameter int WEIGHT_TABLE_DEPTH = msna_pkg::WEIGHT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  msna_pkg::in_beat_t         in_data,
  output logic                       empty,
  input  logic                       pop,
  output msna_pkg::out_beat_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [msna_pkg::BW_W-1:0]  cfg_wr_data
);
  import msna_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [BW_W-1:0]   bw_r;
  logic [BW_W-1:0]   h_eff;
  logic [2*BW_W-1:0] hsq_r;
  logic [DEN_W-1:0]  den;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] n_r;
  logic          busy_r;
  logic          start_r;
  logic          in_acc;
  logic          store_wr;
  logic          out_acc;
  logic          out_valid;

  logic [IW-1:0] k_addr, s_addr;
  logic [PT_W-1:0] k_data, s_data;
  logic [PT_W-1:0] wr_pt;

  logic  mq_push, mq_full, mq_pop, mq_empty;
  mean_t mq_wdata, mq_rdata;

  // a zero bandwidth acts as the smallest one, a raw value of one
  assign h_eff = (bw_r == '0) ? BW_W'(1) : bw_r;
  assign den   = {hsq_r, 13'b0};

  assign full      = busy_r;
  assign in_acc    = push && !busy_r;
  assign store_wr  = in_acc && (count_r < CW'(MAX_POINTS));
  assign count_inc = store_wr ? (count_r + CW'(1)) : count_r;
  assign wr_pt     = {in_data.coord_y, in_data.coord_x};

  assign empty   = !out_valid;
  assign out_acc = pop && out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= BW_RESET;
    end else if (cfg_wr_en) begin
      bw_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    hsq_r <= h_eff * h_eff;
  end

  // load points; the final one latches the count and starts the kernel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      n_r     <= '0;
      busy_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (in_acc) begin
        if (in_data.last_point) begin
          n_r     <= count_inc;
          count_r <= '0;
          busy_r  <= 1'b1;
          start_r <= 1'b1;
        end else begin
          count_r <= count_inc;
        end
      end
      if (out_acc && out_data.last_result) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one store copy per reader so kernel and search read independently
  msna_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_store_k (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (wr_pt),
    .rd_addr (k_addr),
    .rd_data (k_data)
  );

  msna_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_store_s (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (wr_pt),
    .rd_addr (s_addr),
    .rd_data (s_data)
  );

  msna_kernel #(
    .MAX_POINTS         (MAX_POINTS),
    .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
  ) u_kernel (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .n_pts   (n_r),
    .den     (den),
    .rd_addr (k_addr),
    .rd_data (k_data),
    .q_push  (mq_push),
    .q_data  (mq_wdata),
    .q_full  (mq_full)
  );

  msna_queue u_mean_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mq_push),
    .wr_data (mq_wdata),
    .full    (mq_full),
    .rd_en   (mq_pop),
    .rd_data (mq_rdata),
    .empty   (mq_empty)
  );

  msna_nearest #(
    .MAX_POINTS (MAX_POINTS)
  ) u_nearest (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_pts     (n_r),
    .q_empty   (mq_empty),
    .q_pop     (mq_pop),
    .q_data    (mq_rdata),
    .rd_addr   (s_addr),
    .rd_data   (s_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_take  (out_acc)
  );

endmodule
`default_nettype wire

// File: rtl/msna_ram.sv
`default_nettype none
module msna_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/msna_queue.sv
`default_nettype none
module msna_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  msna_pkg::mean_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output msna_pkg::mean_t rd_data,
  output logic            empty
);
  import msna_pkg::*;

  mean_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= !wp_r;
      end
      if (do_rd) begin
        rp_r <= !rp_r;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/msna_kernel.sv
`default_nettype none
module msna_kernel #(
  parameter int MAX_POINTS         = msna_pkg::MAX_POINTS_DEF,
  parameter int WEIGHT_TABLE_DEPTH = msna_pkg::WEIGHT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     n_pts,
  input  logic [msna_pkg::DEN_W-1:0]          den,
  output logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
  input  logic [msna_pkg::PT_W-1:0]           rd_data,
  output logic                                q_push,
  output msna_pkg::mean_t                     q_data,
  input  logic                                q_full
);
  import msna_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int KW   = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int D2W  = 34;
  localparam int RW   = DEN_W + KW;
  localparam int ACW  = 2 * COORD_W + IW + 1;
  localparam int WSW  = WEIGHT_W + IW;
  localparam int QB   = 17;
  localparam int RW2A = ACW + 2;
  localparam int RW2B = WSW + QB + 1;
  localparam int RW2  = (RW2A > RW2B) ? RW2A : RW2B;
  localparam int DCW  = $clog2(QB + 1);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_FETCH  = 3'd1;
  localparam logic [2:0] F_STREAM = 3'd2;
  localparam logic [2:0] F_DRAIN  = 3'd3;
  localparam logic [2:0] F_DIV    = 3'd4;
  localparam logic [2:0] F_PUSH   = 3'd5;

  // weight table, zero past the configured depth
  logic [WEIGHT_W-1:0] rom [2**KW];
  for (genvar g = 0; g < 2**KW; g++) begin : g_rom
    if (g < WEIGHT_TABLE_DEPTH) begin : g_used
      localparam logic [63:0] S_G = (64'(g) << 32) / WEIGHT_TABLE_DEPTH;
      localparam logic [WEIGHT_W-1:0] E_G = table_entry(64'(g), S_G);
      assign rom[g] = E_G;
    end else begin : g_pad
      assign rom[g] = '0;
    end
  end

  logic [2:0]     state_r;
  logic [CW-1:0]  i_r;
  logic [CW-1:0]  j_r;
  logic           cap_r;
  logic           rd_v_r;
  logic           v1_r, v2_r, v3_r, vt_r, vm_r;
  logic [KW:0]    vd_r;
  logic [DCW-1:0] dcnt_r;
  logic           pipe_busy;
  logic           is_last;

  logic signed [COORD_W-1:0] xi_r, yi_r;
  logic signed [COORD_W:0]   dx1_r, dy1_r;
  logic signed [COORD_W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic signed [33:0]        sqx, sqy;
  logic [32:0]               sqx2_r, sqy2_r;
  logic [D2W-1:0]            d2_3_r;

  logic [RW-1:0]             rem_r [KW+1];
  logic [KW-1:0]             q_r   [KW+1];
  logic                      far_r [KW+1];
  logic signed [COORD_W-1:0] xs_r  [KW+1];
  logic signed [COORD_W-1:0] ys_r  [KW+1];

  logic [WEIGHT_W-1:0]       w_r, wm_r;
  logic signed [COORD_W-1:0] xt_r, yt_r;
  logic signed [32:0]        px, py;
  logic signed [32:0]        px_r, py_r;
  logic signed [ACW-1:0]     sx_r, sy_r;
  logic [WSW-1:0]            ws_r;

  logic [ACW-1:0]            magx, magy;
  logic [RW2-1:0]            remx_r, remy_r, dsh_r;
  logic [QB-1:0]             qx_r, qy_r;
  logic                      sgx_r, sgy_r;
  logic                      gex, gey;

  assign pipe_busy = rd_v_r | v1_r | v2_r | v3_r | (|vd_r) | vt_r | vm_r;
  assign is_last   = ((i_r + CW'(1)) == n_pts);
  assign rd_addr   = (state_r == F_FETCH) ? i_r[IW-1:0] : j_r[IW-1:0];
  assign q_push    = (state_r == F_PUSH) && !q_full;

  assign q_data.point_index = OIDX_W'(i_r[IW-1:0]);
  assign q_data.mean_x      = sgx_r ? -MEAN_W'(qx_r) : MEAN_W'(qx_r);
  assign q_data.mean_y      = sgy_r ? -MEAN_W'(qy_r) : MEAN_W'(qy_r);
  assign q_data.last        = is_last;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      cap_r   <= 1'b0;
      rd_v_r  <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vd_r    <= '0;
      vt_r    <= 1'b0;
      vm_r    <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      rd_v_r <= (state_r == F_STREAM);
      v1_r   <= rd_v_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      vd_r   <= {vd_r[KW-1:0], v3_r};
      vt_r   <= vd_r[KW];
      vm_r   <= vt_r;
      case (state_r)
        F_IDLE: begin
          if (start) begin
            i_r     <= '0;
            state_r <= F_FETCH;
          end
        end
        F_FETCH: begin
          cap_r   <= 1'b1;
          j_r     <= '0;
          state_r <= F_STREAM;
        end
        F_STREAM: begin
          cap_r <= 1'b0;
          j_r   <= j_r + CW'(1);
          if (j_r == n_pts - CW'(1)) begin
            state_r <= F_DRAIN;
          end
        end
        F_DRAIN: begin
          if (!pipe_busy) begin
            dcnt_r  <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(QB - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            i_r     <= i_r + CW'(1);
            state_r <= is_last ? F_IDLE : F_FETCH;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign sqx = dx1_r * dx1_r;
  assign sqy = dy1_r * dy1_r;
  assign px  = $signed({1'b0, w_r}) * xt_r;
  assign py  = $signed({1'b0, w_r}) * yt_r;

  // front of the pair pipeline: distance, square, sum
  always_ff @(posedge clk) begin
    if (cap_r) begin
      xi_r <= $signed(rd_data[COORD_W-1:0]);
      yi_r <= $signed(rd_data[PT_W-1:COORD_W]);
    end
    x1_r   <= $signed(rd_data[COORD_W-1:0]);
    y1_r   <= $signed(rd_data[PT_W-1:COORD_W]);
    dx1_r  <= (COORD_W+1)'(xi_r) - (COORD_W+1)'($signed(rd_data[COORD_W-1:0]));
    dy1_r  <= (COORD_W+1)'(yi_r) - (COORD_W+1)'($signed(rd_data[PT_W-1:COORD_W]));
    sqx2_r <= sqx[32:0];
    sqy2_r <= sqy[32:0];
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    d2_3_r <= {1'b0, sqx2_r} + {1'b0, sqy2_r};
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    // table index = d2*depth/den; at or past den the weight is zero
    rem_r[0] <= RW'(d2_3_r) * RW'(WEIGHT_TABLE_DEPTH);
    q_r[0]   <= '0;
    far_r[0] <= (DEN_W'(d2_3_r) >= den);
    xs_r[0]  <= x3_r;
    ys_r[0]  <= y3_r;
  end

  for (genvar s = 0; s < KW; s++) begin : g_div
    localparam int B = KW - 1 - s;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den) << B;
    assign ge  = (rem_r[s] >= dsh);
    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? (rem_r[s] - dsh) : rem_r[s];
      q_r[s+1]   <= q_r[s] | (ge ? (KW'(1) << B) : KW'(0));
      far_r[s+1] <= far_r[s];
      xs_r[s+1]  <= xs_r[s];
      ys_r[s+1]  <= ys_r[s];
    end
  end

  assign magx = sx_r[ACW-1] ? ACW'(-sx_r) : ACW'(sx_r);
  assign magy = sy_r[ACW-1] ? ACW'(-sy_r) : ACW'(sy_r);
  assign gex  = (remx_r >= dsh_r);
  assign gey  = (remy_r >= dsh_r);

  // back of the pair pipeline: weight, products, sums; then the mean divide
  always_ff @(posedge clk) begin
    w_r  <= far_r[KW] ? '0 : rom[q_r[KW]];
    xt_r <= xs_r[KW];
    yt_r <= ys_r[KW];
    px_r <= px;
    py_r <= py;
    wm_r <= w_r;
    if (state_r == F_FETCH) begin
      sx_r <= '0;
      sy_r <= '0;
      ws_r <= '0;
    end else if (vm_r) begin
      sx_r <= sx_r + ACW'(px_r);
      sy_r <= sy_r + ACW'(py_r);
      ws_r <= ws_r + WSW'(wm_r);
    end
    // mean = (2|S| + W) / 2W, sign restored afterwards
    if (state_r == F_DRAIN) begin
      remx_r <= (RW2'(magx) << 1) + RW2'(ws_r);
      remy_r <= (RW2'(magy) << 1) + RW2'(ws_r);
      dsh_r  <= RW2'(ws_r) << QB;
      sgx_r  <= sx_r[ACW-1];
      sgy_r  <= sy_r[ACW-1];
      qx_r   <= '0;
      qy_r   <= '0;
    end else if (state_r == F_DIV) begin
      remx_r <= gex ? (remx_r - dsh_r) : remx_r;
      remy_r <= gey ? (remy_r - dsh_r) : remy_r;
      qx_r   <= {qx_r[QB-2:0], gex};
      qy_r   <= {qy_r[QB-2:0], gey};
      dsh_r  <= dsh_r >> 1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/msna_nearest.sv
`default_nettype none
module msna_nearest #(
  parameter int MAX_POINTS = msna_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(MAX_POINTS+1)-1:0] n_pts,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  msna_pkg::mean_t                 q_data,
  output logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  input  logic [msna_pkg::PT_W-1:0]       rd_data,
  output logic                            out_valid,
  output msna_pkg::out_beat_t             out_data,
  input  logic                            out_take
);
  import msna_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = 2 * MEAN_W;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_SCAN  = 2'd1;
  localparam logic [1:0] B_DRAIN = 2'd2;

  logic [1:0]    state_r;
  logic [CW-1:0] j_r;
  logic          rv_r, v1_r, v2_r;
  logic          bv_r;
  logic          ov_r;
  logic          pipe_busy;

  mean_t                    cur_r;
  logic [IW-1:0]            j0_r, j1_r, j2_r;
  logic signed [MEAN_W-1:0] dx1_r, dy1_r;
  logic signed [SW-1:0]     sqx, sqy;
  logic [SW-2:0]            sqx2_r, sqy2_r;
  logic [SW-1:0]            d2;
  logic [SW-1:0]            best_r;
  logic [IW-1:0]            bidx_r;
  logic                     better;
  out_beat_t                od_r;

  assign pipe_busy = rv_r | v1_r | v2_r;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign rd_addr   = j_r[IW-1:0];
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign sqx    = dx1_r * dx1_r;
  assign sqy    = dy1_r * dy1_r;
  assign d2     = {1'b0, sqx2_r} + {1'b0, sqy2_r};
  assign better = v2_r && (!bv_r || (d2 < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      j_r     <= '0;
      rv_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      bv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      rv_r <= (state_r == B_SCAN);
      v1_r <= rv_r;
      v2_r <= v1_r;
      if (better) begin
        bv_r <= 1'b1;
      end
      if (out_take) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            j_r     <= '0;
            bv_r    <= 1'b0;
            state_r <= B_SCAN;
          end
        end
        B_SCAN: begin
          j_r <= j_r + CW'(1);
          if (j_r == n_pts - CW'(1)) begin
            state_r <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (!pipe_busy && !ov_r) begin
            ov_r    <= 1'b1;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    j0_r   <= j_r[IW-1:0];
    j1_r   <= j0_r;
    dx1_r  <= MEAN_W'($signed(rd_data[COORD_W-1:0])) - cur_r.mean_x;
    dy1_r  <= MEAN_W'($signed(rd_data[PT_W-1:COORD_W])) - cur_r.mean_y;
    j2_r   <= j1_r;
    sqx2_r <= sqx[SW-2:0];
    sqy2_r <= sqy[SW-2:0];
    // strict compare keeps the lowest index on a tie
    if (better) begin
      best_r <= d2;
      bidx_r <= j2_r;
    end
    if ((state_r == B_DRAIN) && !pipe_busy && !ov_r) begin
      od_r.point_index   <= cur_r.point_index;
      od_r.cluster_index <= OIDX_W'(bidx_r);
      od_r.last_result   <= cur_r.last;
    end
  end

endmodule
`default_nettype wire

// File: tb/msna_assign_checker.sv
module msna_assign_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      full,
  input  msna_pkg::in_beat_t        in_data,
  input  logic                      empty,
  input  logic                      pop,
  input  msna_pkg::out_beat_t       out_data,
  input  logic                      cfg_wr_en,
  input  logic [msna_pkg::BW_W-1:0] cfg_wr_data,
  output int                        fail_count,
  output int                        pending
);
  import msna_pkg::*;

  localparam int NPTS  = 64;
  localparam int DEPTH = 256;

  logic [15:0]        weight_lut [DEPTH];
  logic signed [15:0] pt_x [NPTS];
  logic signed [15:0] pt_y [NPTS];
  int                 pt_n;
  logic [15:0]        bw;
  out_beat_t          cluster_q [$];

  // Q0.16 Gaussian weight for table slot k
  function automatic logic [15:0] gauss_weight(int k);
    longint unsigned s, term, e;
    longint          acc;
    if (k == 0) return 16'hFFFF;
    s    = (64'(k) << 32) / DEPTH;
    term = 64'd1 << 32;
    acc  = longint'(term);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * s) >> 32) / longint'(n);
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    e = longint'(acc);
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    for (int r = 0; r < 4; r++) e = (e * e + (64'd1 << 31)) >> 32;
    e = (e + 64'd32768) >> 16;
    if (e > 64'd65535) e = 64'd65535;
    return e[15:0];
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // one mean-shift pass over the stored set, queue one assignment per point
  function automatic void shift_and_assign();
    longint h, den, xi, yi, dx, dy, d2, k, w, ws, sx, sy, mx, my, bestd;
    int     best;
    out_beat_t a;
    h   = (bw == 0) ? 1 : longint'(bw);
    den = (h * h) << 13;
    for (int i = 0; i < pt_n; i++) begin
      xi = pt_x[i];
      yi = pt_y[i];
      ws = 0; sx = 0; sy = 0;
      for (int j = 0; j < pt_n; j++) begin
        dx = xi - pt_x[j];
        dy = yi - pt_y[j];
        d2 = dx * dx + dy * dy;
        k  = d2 * DEPTH / den;
        w  = (k < DEPTH) ? longint'(weight_lut[k]) : 0;
        ws += w;
        sx += w * pt_x[j];
        sy += w * pt_y[j];
      end
      if (ws == 0) ws = 1;
      mx = round_div(sx, ws);
      my = round_div(sy, ws);
      best = 0;
      bestd = 0;
      for (int j = 0; j < pt_n; j++) begin
        dx = pt_x[j] - mx;
        dy = pt_y[j] - my;
        d2 = dx * dx + dy * dy;
        if (j == 0 || d2 < bestd) begin
          bestd = d2;
          best  = j;
        end
      end
      a.point_index   = i[5:0];
      a.cluster_index = best[5:0];
      a.last_result   = (i + 1 == pt_n);
      cluster_q.push_back(a);
    end
    pt_n = 0;
  endfunction

  initial begin
    for (int k = 0; k < DEPTH; k++) weight_lut[k] = gauss_weight(k);
    fail_count = 0;
    pt_n = 0;
    bw = BW_RESET;
  end

  assign pending = cluster_q.size();

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      pt_n = 0;
      bw   = BW_RESET;
    end else begin
      // compare results first: they never depend on a point taken this edge
      if (pop && !empty) begin
        if (cluster_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data);
          fail_count++;
        end else begin
          want = cluster_q.pop_front();
          if (out_data.point_index !== want.point_index) begin
            $display("%0t: point_index expected %0d actual %0d", $time,
                     want.point_index, out_data.point_index);
            fail_count++;
          end
          if (out_data.cluster_index !== want.cluster_index) begin
            $display("%0t: cluster_index expected %0d actual %0d", $time,
                     want.cluster_index, out_data.cluster_index);
            fail_count++;
          end
          if (out_data.last_result !== want.last_result) begin
            $display("%0t: last_result expected %0b actual %0b", $time,
                     want.last_result, out_data.last_result);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) bw = cfg_wr_data;
      if (push && !full) begin
        if (pt_n < NPTS) begin
          pt_x[pt_n] = in_data.coord_x;
          pt_y[pt_n] = in_data.coord_y;
          pt_n++;
        end
        if (in_data.last_point) shift_and_assign();
      end
    end
  end
endmodule

// File: tb/tb.sv
module tb;
  import msna_pkg::*;

  // cycles with no beat on either channel before the run is declared hung
  localparam int STALL_LIMIT = 150000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  in_beat_t            in_data = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_beat_t           out_data;
  logic                cfg_wr_en = 1'b0;
  logic [BW_W-1:0]     cfg_wr_data = '0;
  int                  fail_count;
  int                  pending;

  // receiver pacing state
  int                  pop_stall = 0;
  int                  hold_seq = 0;
  int                  hold_seen = 0;
  logic                steady = 1'b0;
  int                  quiet_cycles = 0;
  int                  items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mean_shift_nearest_assign_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  msna_assign_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Result side: pop at random, mostly short stalls with a few long ones.
  // A bump of hold_seq starts one long hold-off so the block backs up.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      pop_stall = 3000;
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (steady) begin
      pop <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        pop_stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("mean_shift_nearest_assign_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one point and hold it until accepted, then maybe go idle.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    in_beat_t b;
    int       r;
    int       gap;
    b.coord_x    = x;
    b.coord_y    = y;
    b.last_point = last;
    in_data <= b;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!steady) begin
      if (r >= 95) gap = $urandom_range(10, 40);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop push and wait until every predicted assignment has been popped.
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_bandwidth(logic [BW_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One set of n points around a center; spread of 0 means full range noise.
  task automatic send_cluster_set(int n, int cx, int cy, int spread);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if (spread == 0 || $urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
      end else begin
        x = cx + $urandom_range(0, 2 * spread) - spread;
        y = cy + $urandom_range(0, 2 * spread) - spread;
      end
      send_point(16'(x), 16'(y), i == n - 1);
    end
  endtask

  initial begin
    int n, sp;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point at the coordinate extremes
    send_point(16'sh7FFF, -16'sh8000, 1'b1);
    // opposite corners plus origin
    send_point(-16'sh8000, -16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b1);
    // duplicates: nearest-sample tie goes to the first index
    send_point(16'sh0100, 16'sh0100, 1'b0);
    send_point(16'sh0100, 16'sh0100, 1'b0);
    send_point(16'sh0600, 16'sh0600, 1'b0);
    send_point(16'sh0600, 16'sh0600, 1'b1);
    // two tight groups
    send_point(16'sh1000, 16'sh1000, 1'b0);
    send_point(16'sh1080, 16'sh0F80, 1'b0);
    send_point(-16'sh2000, 16'sh3000, 1'b0);
    send_point(-16'sh2040, 16'sh3040, 1'b1);
    drain();

    // zero bandwidth behaves as the smallest one
    set_bandwidth(16'd0);
    send_point(16'sh0001, 16'sh0000, 1'b0);
    send_point(16'sh0000, 16'sh0001, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b1);
    drain();

    set_bandwidth(16'hFFFF);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(-16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh5555, -16'sh2AAB, 1'b0);
    send_point(-16'sh8000, -16'sh8000, 1'b1);
    drain();

    // overfill the store: extra points drop, the dropped final one still starts
    set_bandwidth(BW_RESET);
    send_cluster_set(66, 0, 0, 12000);
    drain();

    // long receiver hold-off while the next sets keep coming
    hold_seq <= hold_seq + 1;
    send_cluster_set(10, 2000, -3000, 4000);
    send_cluster_set(6, -5000, 1000, 3000);
    drain();

    // back-to-back stretch with no idling
    steady <= 1'b1;
    set_bandwidth(16'd1);
    send_cluster_set(5, 100, 100, 3);
    send_cluster_set(4, -300, 200, 2000);
    drain();
    steady <= 1'b0;

    // random sets and bandwidths
    while (items_sent < 120) begin
      case ($urandom_range(0, 4))
        0: set_bandwidth(16'd1);
        1: set_bandwidth(16'hFFFF);
        2: set_bandwidth(16'($urandom_range(64, 4000)));
        default: ;
      endcase
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      sp = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8000);
      send_cluster_set(n, $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768, sp);
      drain();
    end

    if (fail_count == 0) begin
      $display("mean_shift_nearest_assign_core test passed");
    end else begin
      $display("mean_shift_nearest_assign_core test failed");
    end
    $finish;
  end
endmodule
